@@ src/pos_pkg.sv @@
// Shared constants, types and the cosine table builder for the oscillator step block.
`default_nettype none

package pos_pkg;

  localparam int MAX_FORCING     = 4;
  localparam int N_PAIRS         = 4;
  localparam int COS_TABLE_DEPTH = 1024;
  localparam int COS_AW          = $clog2(COS_TABLE_DEPTH);

  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 50;
  localparam int G_W    = 40;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_ANGLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCITATION = 2'd2;

  localparam int     DAMP_LINEAR_Q24 = 1677722;
  localparam int     STIFF_ONE_Q29   = 536870912;
  localparam longint LOCK_THRESHOLD  = 64'sd5497558139;

  localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [8] = '{2, 12, 30, 56, 90, 132, 182, 240};

  typedef logic signed [MUL_W-1:0]  mul_op_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [15:0]       cos_t;
  typedef logic [COS_AW-1:0]        cos_addr_t;
  typedef cos_t                     cos_tab_t [COS_TABLE_DEPTH];

  typedef enum logic [17:0] {
    ST_IDLE  = 18'b000000000000000001,
    ST_SQ    = 18'b000000000000000010,
    ST_F0    = 18'b000000000000000100,
    ST_F1    = 18'b000000000000001000,
    ST_F2    = 18'b000000000000010000,
    ST_F3    = 18'b000000000000100000,
    ST_PUMP  = 18'b000000000001000000,
    ST_DAMPH = 18'b000000000010000000,
    ST_STIFF = 18'b000000000100000000,
    ST_DAMPL = 18'b000000001000000000,
    ST_ACC   = 18'b000000010000000000,
    ST_VELH  = 18'b000000100000000000,
    ST_VELL  = 18'b000001000000000000,
    ST_VEL   = 18'b000010000000000000,
    ST_POSM  = 18'b000100000000000000,
    ST_POS   = 18'b001000000000000000,
    ST_CORR  = 18'b010000000000000000,
    ST_LOCK  = 18'b100000000000000000
  } state_t;

  // Q1.15 cosine over one turn, Taylor series on the folded angle
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t          tab;
    longint unsigned   n;
    longint unsigned   ang;
    longint unsigned   a2;
    longint unsigned   term;
    longint            sum;
    longint            q;
    cos_t              q16;
    logic              neg;
    for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
      n = longint'(k);
      if (2 * n > longint'(COS_TABLE_DEPTH)) n = longint'(COS_TABLE_DEPTH) - n;
      ang = (n * TWO_PI_Q30 + longint'(COS_TABLE_DEPTH / 2)) / COS_TABLE_DEPTH;
      if (ang > PI_Q30) ang = PI_Q30;
      neg = 1'b0;
      if (ang > HALF_PI_Q30) begin
        ang = PI_Q30 - ang;
        neg = 1'b1;
      end
      a2   = (ang * ang) >> 30;
      term = 64'd1 << 30;
      sum  = longint'(term);
      for (int j = 1; j <= 8; j++) begin
        term = ((term * a2) >> 30) / TAYLOR_DIV[j-1];
        if (j % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      q = (sum + 16384) / 32768;
      if (q > 32767) q = 32767;
      q16 = q[15:0];
      tab[k] = neg ? -q16 : q16;
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

@@ src/parametron_oscillator_step.sv @@
// Top level: one integration step of the pumped oscillator per transaction.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | input_count, amplitude_0..3, phase_0..3
//  out     | out_valid / out_stall| logic_bit, position_out
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (phase_step,
//          |                      | step_angle, excitation)
//
// A transaction runs through one 33x33 multiplier and one cosine ROM port under
// the sequencer; the next one is taken the cycle after. The result loads into
// the output register unless a previous result is still stalled there, in
// which case the sequencer holds on its last step. Synchronous active-low reset
// clears state, config and the output valid; the cosine table is constant and
// needs no clearing.
`default_nettype none

module parametron_oscillator_step (
  input  wire                              clk,
  input  wire                              rst_n,

  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [2:0]                       in_input_count,
  input  wire  signed [15:0]               in_amplitude_0,
  input  wire  [15:0]                      in_phase_0,
  input  wire  signed [15:0]               in_amplitude_1,
  input  wire  [15:0]                      in_phase_1,
  input  wire  signed [15:0]               in_amplitude_2,
  input  wire  [15:0]                      in_phase_2,
  input  wire  signed [15:0]               in_amplitude_3,
  input  wire  [15:0]                      in_phase_3,

  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             out_logic_bit,
  output logic signed [31:0]               out_position_out,

  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [pos_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [31:0]                      cfg_data
);
  import pos_pkg::*;

  localparam prod_t LOCK_HI = PROD_W'(LOCK_THRESHOLD);
  localparam prod_t LOCK_LO = -PROD_W'(LOCK_THRESHOLD);

  state_t                    state_r, state_nxt;

  logic [31:0]               phase_step_r;
  logic [23:0]               step_angle_r;
  logic signed [15:0]        excitation_r;

  logic [31:0]               theta_r;
  logic signed [31:0]        pos_r;
  logic signed [31:0]        vel_r;
  logic                      held_r;

  logic signed [15:0]        in_amp [N_PAIRS];
  logic [15:0]               in_ph  [N_PAIRS];
  logic signed [15:0]        amp_r  [N_PAIRS];
  logic [15:0]               ph_r   [N_PAIRS];
  logic [31:0]               psum   [N_PAIRS];
  logic [2:0]                cnt_eff;

  logic [G_W-1:0]            g_r;
  logic signed [31:0]        stiff_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   tmp_r;

  logic                      out_valid_r;
  logic                      out_bit_r;
  logic signed [31:0]        out_pos_r;

  cos_addr_t                 cos_addr;
  cos_t                      cos_q;
  logic                      mul_en;
  mul_op_t                   mul_a, mul_b;
  prod_t                     prod_r;

  logic [31:0]               ax;
  logic [38:0]               x2;
  logic [15:0]               gh;
  logic [23:0]               gl;
  logic signed [ACC_W-25:0]  ahi;
  logic [23:0]               alo;
  mul_op_t                   h_op;

  logic                      in_acc;
  logic                      lock_go;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-32:0] top;
    top = v[ACC_W-1:31];
    if (top == '0 || top == '1) return v[31:0];
    return v[ACC_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
  endfunction

  pos_cos_rom u_cos_rom (
    .clk    (clk),
    .addr   (cos_addr),
    .data_r (cos_q)
  );

  pos_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign in_amp[0] = in_amplitude_0;
  assign in_amp[1] = in_amplitude_1;
  assign in_amp[2] = in_amplitude_2;
  assign in_amp[3] = in_amplitude_3;
  assign in_ph[0]  = in_phase_0;
  assign in_ph[1]  = in_phase_1;
  assign in_ph[2]  = in_phase_2;
  assign in_ph[3]  = in_phase_3;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign lock_go   = (state_r == ST_LOCK) && (!out_valid_r || !out_stall);
  assign cfg_ready = 1'b1;

  assign out_valid        = out_valid_r;
  assign out_logic_bit    = out_bit_r;
  assign out_position_out = out_pos_r;

  assign cnt_eff = (in_input_count > 3'(MAX_FORCING)) ? 3'(MAX_FORCING) : in_input_count;

  assign ax   = pos_r[31] ? 32'(-pos_r) : 32'(pos_r);
  assign x2   = prod_r[62:24];
  assign gh   = g_r[G_W-1:24];
  assign gl   = g_r[23:0];
  assign ahi  = acc_r[ACC_W-1:24];
  assign alo  = acc_r[23:0];
  assign h_op = $signed({9'b0, step_angle_r});

  always_comb begin
    for (int i = 0; i < N_PAIRS; i++) begin
      psum[i] = theta_r + {ph_r[i], 16'b0};
    end
  end

  // sequencer: each step issues one ROM read and at most one multiply
  always_comb begin
    state_nxt = state_r;
    cos_addr  = theta_r[31 -: COS_AW];
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cos_addr  = psum[0][31 -: COS_AW];
        mul_en    = 1'b1;
        mul_a     = $signed({1'b0, ax});
        mul_b     = $signed({1'b0, ax});
        state_nxt = ST_F0;
      end
      ST_F0: begin
        cos_addr  = psum[1][31 -: COS_AW];
        mul_en    = 1'b1;
        mul_a     = MUL_W'(amp_r[0]);
        mul_b     = MUL_W'(cos_q);
        state_nxt = ST_F1;
      end
      ST_F1: begin
        cos_addr  = psum[2][31 -: COS_AW];
        mul_en    = 1'b1;
        mul_a     = MUL_W'(amp_r[1]);
        mul_b     = MUL_W'(cos_q);
        state_nxt = ST_F2;
      end
      ST_F2: begin
        cos_addr  = psum[3][31 -: COS_AW];
        mul_en    = 1'b1;
        mul_a     = MUL_W'(amp_r[2]);
        mul_b     = MUL_W'(cos_q);
        state_nxt = ST_F3;
      end
      ST_F3: begin
        // pump reads cos(2*theta)
        cos_addr  = theta_r[30 -: COS_AW];
        mul_en    = 1'b1;
        mul_a     = MUL_W'(amp_r[3]);
        mul_b     = MUL_W'(cos_q);
        state_nxt = ST_PUMP;
      end
      ST_PUMP: begin
        mul_en    = 1'b1;
        mul_a     = MUL_W'(excitation_r);
        mul_b     = MUL_W'(cos_q);
        state_nxt = ST_DAMPH;
      end
      ST_DAMPH: begin
        mul_en    = 1'b1;
        mul_a     = $signed({17'b0, gh});
        mul_b     = MUL_W'(vel_r);
        state_nxt = ST_STIFF;
      end
      ST_STIFF: begin
        mul_en    = 1'b1;
        mul_a     = MUL_W'(stiff_r);
        mul_b     = MUL_W'(pos_r);
        state_nxt = ST_DAMPL;
      end
      ST_DAMPL: begin
        mul_en    = 1'b1;
        mul_a     = $signed({9'b0, gl});
        mul_b     = MUL_W'(vel_r);
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        state_nxt = ST_VELH;
      end
      ST_VELH: begin
        mul_en    = 1'b1;
        mul_a     = MUL_W'(ahi);
        mul_b     = h_op;
        state_nxt = ST_VELL;
      end
      ST_VELL: begin
        mul_en    = 1'b1;
        mul_a     = $signed({9'b0, alo});
        mul_b     = h_op;
        state_nxt = ST_VEL;
      end
      ST_VEL: begin
        state_nxt = ST_POSM;
      end
      ST_POSM: begin
        mul_en    = 1'b1;
        mul_a     = MUL_W'(vel_r);
        mul_b     = h_op;
        state_nxt = ST_POS;
      end
      ST_POS: begin
        state_nxt = ST_CORR;
      end
      ST_CORR: begin
        mul_en    = 1'b1;
        mul_a     = MUL_W'(pos_r);
        mul_b     = MUL_W'(cos_q);
        state_nxt = ST_LOCK;
      end
      ST_LOCK: begin
        if (lock_go) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_step_r <= '0;
      step_angle_r <= '0;
      excitation_r <= '0;
      theta_r      <= '0;
      pos_r        <= '0;
      vel_r        <= '0;
      held_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PHASE_STEP: phase_step_r <= cfg_data;
          CFG_STEP_ANGLE: step_angle_r <= cfg_data[23:0];
          CFG_EXCITATION: excitation_r <= $signed(cfg_data[15:0]);
          default: ;
        endcase
      end
      if (state_r == ST_VEL) begin
        vel_r   <= sat32(tmp_r + ACC_W'(prod_r >>> 24));
        theta_r <= theta_r + phase_step_r;
      end
      if (state_r == ST_POS) begin
        pos_r <= sat32(ACC_W'(pos_r) + ACC_W'(prod_r >>> 24));
      end
      if (lock_go) begin
        if (prod_r > LOCK_HI) held_r <= 1'b1;
        else if (prod_r < LOCK_LO) held_r <= 1'b0;
      end
      if (lock_go) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < N_PAIRS; i++) begin
        // drop pairs beyond the count
        amp_r[i] <= (3'(i) < cnt_eff) ? in_amp[i] : 16'sd0;
        ph_r[i]  <= in_ph[i];
      end
    end
    case (state_r)
      ST_F0:    g_r     <= G_W'(DAMP_LINEAR_Q24) + G_W'(x2) + G_W'(x2 >> 1);
      ST_F1:    acc_r   <= ACC_W'(prod_r);
      ST_F2:    acc_r   <= acc_r + ACC_W'(prod_r);
      ST_F3:    acc_r   <= acc_r + ACC_W'(prod_r);
      ST_PUMP:  acc_r   <= acc_r + ACC_W'(prod_r);
      ST_DAMPH: begin
        stiff_r <= 32'(STIFF_ONE_Q29) - 32'(prod_r);
        acc_r   <= acc_r >>> 3;
      end
      ST_STIFF: acc_r   <= acc_r - ACC_W'(prod_r);
      ST_DAMPL: acc_r   <= acc_r - ACC_W'(prod_r >>> 29);
      ST_ACC:   acc_r   <= acc_r - ACC_W'(prod_r >>> 24);
      ST_VELL:  tmp_r   <= ACC_W'(vel_r) + ACC_W'(prod_r);
      default: ;
    endcase
    if (lock_go) begin
      out_pos_r <= pos_r;
      if (prod_r > LOCK_HI) out_bit_r <= 1'b1;
      else if (prod_r < LOCK_LO) out_bit_r <= 1'b0;
      else out_bit_r <= held_r;
    end
  end

  a_lock_timing: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##17 (state_r == ST_LOCK))
    else $error("sequencer did not reach the lock step on schedule");

  a_held_only_at_lock: assert property (@(posedge clk) disable iff (!rst_n)
    !lock_go |=> $stable(held_r))
    else $error("held bit changed outside the lock step");

  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (out_pos_r == pos_r) && (out_bit_r == held_r))
    else $error("output register disagrees with oscillator state");

endmodule

`default_nettype wire

@@ src/pos_cos_rom.sv @@
// Cosine lookup table with registered read.
`default_nettype none

module pos_cos_rom (
  input  wire                  clk,
  input  pos_pkg::cos_addr_t   addr,
  output pos_pkg::cos_t        data_r
);
  import pos_pkg::*;

  localparam cos_tab_t COS_TAB = build_cos_tab();

  always_ff @(posedge clk) begin
    data_r <= COS_TAB[addr];
  end

endmodule

`default_nettype wire

@@ src/pos_mul.sv @@
// Shared signed multiplier with registered product.
`default_nettype none

module pos_mul (
  input  wire                 clk,
  input  wire                 en,
  input  pos_pkg::mul_op_t    a,
  input  pos_pkg::mul_op_t    b,
  output pos_pkg::prod_t      prod_r
);
  import pos_pkg::*;

  // hold the product when no step issues a multiply
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

endmodule

`default_nettype wire
